### hw/rtl/lsc_pkg.sv
// lsc_pkg: shared types and constants of the link shadowing cache
// table entry layout, shared unit opcodes, register indexes, reset values
// depends on nothing
`default_nettype none

package lsc_pkg;

    localparam int TIME_W = 48;
    localparam int LOSS_W = 16;
    localparam int ALU_W  = TIME_W + 1;

    typedef struct packed {
        logic                      valid;
        logic signed [LOSS_W-1:0]  loss;
        logic [TIME_W-1:0]         stamp;
    } t_entry;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    typedef enum logic [1:0] {
        COND_LOS,
        COND_NLOS,
        COND_NLOS2,
        COND_OTHER
    } t_cond;

    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_COHERENCE,
        REG_DEV_LOS,
        REG_DEV_NLOS,
        REG_DEV_NLOS2,
        REG_CROSSOVER,
        REG_SYMMETRIC
    } t_reg_idx;

    localparam logic [TIME_W-1:0] COHERENCE_RST = 48'd25000000000;
    localparam logic [15:0]       DEV_LOS_RST   = 16'd128;
    localparam logic [15:0]       DEV_NLOS_RST  = 16'd768;
    localparam logic [15:0]       DEV_NLOS2_RST = 16'd1280;
    localparam logic [23:0]       CROSSOVER_RST = 24'd6434;

    localparam logic [ALU_W-1:0]  ROUND_HALF    = 49'd2048;
    localparam logic [20:0]       SAT_POS       = 21'd32767;
    localparam logic [20:0]       SAT_NEG       = 21'd32768;

endpackage

`default_nettype wire

### hw/rtl/lsc_alu.sv
// lsc_alu: shared 49-bit add / subtract unit with a 16x16 multiply mode
// used for elapsed time, coherence compare, product, magnitude, rounding, negation
// depends on lsc_pkg
`default_nettype none

module lsc_alu (
    input  wire lsc_pkg::t_alu_op          i_op,
    input  wire logic [lsc_pkg::ALU_W-1:0] i_a,
    input  wire logic [lsc_pkg::ALU_W-1:0] i_b,
    output logic      [lsc_pkg::ALU_W-1:0] o_res
);

    logic signed [32:0] w_prod;

    // signed sample times unsigned deviation
    assign w_prod = $signed(i_a[15:0]) * $signed({1'b0, i_b[15:0]});

    always_comb begin
        case (i_op)
            lsc_pkg::ALU_ADD: o_res = i_a + i_b;
            lsc_pkg::ALU_SUB: o_res = i_a - i_b;
            lsc_pkg::ALU_MUL: o_res = {{(lsc_pkg::ALU_W-33){w_prod[32]}}, w_prod};
            default:          o_res = '0;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/lsc_table.sv
// lsc_table: per-link entry memory, one write and one registered read port
// runs a clearing pass over every entry after reset; depends on lsc_pkg
`default_nettype none

module lsc_table #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [ADDR_W-1:0]   i_wr_addr,
    input  wire lsc_pkg::t_entry     i_wr_entry,
    input  wire logic                i_rd_en,
    input  wire logic [ADDR_W-1:0]   i_rd_addr,
    output lsc_pkg::t_entry          o_rd_entry,
    output logic                     o_busy
);

    localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(DEPTH - 1);

    lsc_pkg::t_entry    r_mem [DEPTH];
    lsc_pkg::t_entry    r_rd_entry;
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LastAddr) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;
    assign o_busy     = r_clearing;

endmodule

`default_nettype wire

### hw/rtl/link_shadowing_cache.sv
// Link shadowing cache: per-packet log-normal shadowing loss with a per-link
// coherence-time cache of NODE_COUNT*NODE_COUNT entries. After reset the block
// clears the valid marks of all NODE_COUNT*NODE_COUNT entries, one entry a
// cycle; no transaction is taken meanwhile, register writes are. Each
// transaction then runs through one shared add/subtract/multiply unit under a
// sequencer: a cached loss passes the read and compare states to the done
// state and the output register; a redraw also passes the multiply, magnitude,
// rounding, negation and forward-write states, and a reverse-write state when
// the draw is also written to the reverse link. With shadowing disabled or a
// node out of range the result goes straight to the done state. The next
// transaction is taken while a result still waits in the output register.
// depends on lsc_pkg, lsc_alu, lsc_table
`default_nettype none

module link_shadowing_cache #(
    parameter int NODE_COUNT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [5:0]  i_src_node,
    input  wire logic [5:0]  i_dst_node,
    input  wire logic [23:0] i_link_distance,
    input  wire logic [1:0]  i_link_condition,
    input  wire logic [47:0] i_current_time,
    input  wire logic signed [15:0] i_normal_sample,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [15:0] o_shadow_loss,
    output logic             o_redrawn
);

    localparam int          LinkCount = NODE_COUNT * NODE_COUNT;
    localparam int          AddrW     = $clog2(LinkCount);
    localparam logic [31:0] NodeLimit = 32'(NODE_COUNT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MUL,
        S_ABS,
        S_RND,
        S_NEG,
        S_WR1,
        S_WR2,
        S_DONE
    } t_state;

    // configuration registers
    logic        r_enable;
    logic [47:0] r_coherence;
    logic [15:0] r_dev_los;
    logic [15:0] r_dev_nlos;
    logic [15:0] r_dev_nlos2;
    logic [23:0] r_crossover;
    logic        r_symmetric;

    t_state                       r_state;
    logic [AddrW-1:0]             r_fwd;
    logic [AddrW-1:0]             r_rev;
    logic [47:0]                  r_now;
    logic [15:0]                  r_sample;
    logic [15:0]                  r_dev;
    logic [lsc_pkg::ALU_W-1:0]    r_acc;
    logic                         r_neg;
    logic signed [15:0]           r_loss;
    logic                         r_redrawn;
    logic                         r_out_valid;
    logic signed [15:0]           r_out_loss;
    logic                         r_out_redrawn;

    logic                         w_accept;
    logic                         w_cfg_wr;
    lsc_pkg::t_reg_idx            w_reg_idx;
    logic                         w_in_range;
    logic [AddrW-1:0]             w_fwd;
    logic [AddrW-1:0]             w_rev;
    logic [15:0]                  w_dev;
    logic                         w_busy;
    lsc_pkg::t_entry              w_rd_entry;
    lsc_pkg::t_entry              w_wr_entry;
    logic                         w_wr_en;
    logic [AddrW-1:0]             w_wr_addr;
    lsc_pkg::t_alu_op             w_alu_op;
    logic [lsc_pkg::ALU_W-1:0]    w_alu_a;
    logic [lsc_pkg::ALU_W-1:0]    w_alu_b;
    logic [lsc_pkg::ALU_W-1:0]    w_alu_res;
    logic [20:0]                  w_q;
    logic [20:0]                  w_limit;
    logic                         w_out_free;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = lsc_pkg::t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_coherence <= lsc_pkg::COHERENCE_RST;
            r_dev_los   <= lsc_pkg::DEV_LOS_RST;
            r_dev_nlos  <= lsc_pkg::DEV_NLOS_RST;
            r_dev_nlos2 <= lsc_pkg::DEV_NLOS2_RST;
            r_crossover <= lsc_pkg::CROSSOVER_RST;
            r_symmetric <= 1'b1;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                lsc_pkg::REG_ENABLE:    r_enable    <= pwdata[0];
                lsc_pkg::REG_COHERENCE: r_coherence <= pwdata[47:0];
                lsc_pkg::REG_DEV_LOS:   r_dev_los   <= pwdata[15:0];
                lsc_pkg::REG_DEV_NLOS:  r_dev_nlos  <= pwdata[15:0];
                lsc_pkg::REG_DEV_NLOS2: r_dev_nlos2 <= pwdata[15:0];
                lsc_pkg::REG_CROSSOVER: r_crossover <= pwdata[23:0];
                lsc_pkg::REG_SYMMETRIC: r_symmetric <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            lsc_pkg::REG_ENABLE:    prdata = {63'd0, r_enable};
            lsc_pkg::REG_COHERENCE: prdata = {16'd0, r_coherence};
            lsc_pkg::REG_DEV_LOS:   prdata = {48'd0, r_dev_los};
            lsc_pkg::REG_DEV_NLOS:  prdata = {48'd0, r_dev_nlos};
            lsc_pkg::REG_DEV_NLOS2: prdata = {48'd0, r_dev_nlos2};
            lsc_pkg::REG_CROSSOVER: prdata = {40'd0, r_crossover};
            lsc_pkg::REG_SYMMETRIC: prdata = {63'd0, r_symmetric};
            default:                prdata = '0;
        endcase
    end

    // input side
    assign o_in_ready = (r_state == S_IDLE) && !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (32'(i_src_node) < NodeLimit) && (32'(i_dst_node) < NodeLimit);
    assign w_fwd = AddrW'(i_src_node) * AddrW'(NODE_COUNT) + AddrW'(i_dst_node);
    assign w_rev = AddrW'(i_dst_node) * AddrW'(NODE_COUNT) + AddrW'(i_src_node);

    always_comb begin
        case (lsc_pkg::t_cond'(i_link_condition))
            lsc_pkg::COND_LOS:   w_dev = (i_link_distance < r_crossover) ? r_dev_los
                                                                           : r_dev_nlos;
            lsc_pkg::COND_NLOS:  w_dev = r_dev_nlos;
            lsc_pkg::COND_NLOS2: w_dev = r_dev_nlos2;
            default:             w_dev = r_dev_los;
        endcase
    end

    // shared unit operand selection
    always_comb begin
        w_alu_op = lsc_pkg::ALU_SUB;
        w_alu_a  = '0;
        w_alu_b  = '0;
        case (r_state)
            S_READ: begin
                w_alu_a = {1'b0, r_now};
                w_alu_b = {1'b0, w_rd_entry.stamp};
            end
            S_CMP: begin
                w_alu_a = {1'b0, r_coherence};
                w_alu_b = {1'b0, r_acc[47:0]};
            end
            S_MUL: begin
                w_alu_op = lsc_pkg::ALU_MUL;
                w_alu_a  = {33'd0, r_sample};
                w_alu_b  = {33'd0, r_dev};
            end
            S_ABS: begin
                w_alu_b = r_acc;
            end
            S_RND: begin
                w_alu_op = lsc_pkg::ALU_ADD;
                w_alu_a  = r_acc;
                w_alu_b  = lsc_pkg::ROUND_HALF;
            end
            S_NEG: begin
                w_alu_b = r_acc;
            end
            default: ;
        endcase
    end

    lsc_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res)
    );

    assign w_q     = w_alu_res[32:12];
    assign w_limit = r_neg ? lsc_pkg::SAT_NEG : lsc_pkg::SAT_POS;

    // table access
    assign w_wr_en          = (r_state == S_WR1) || (r_state == S_WR2);
    assign w_wr_addr        = (r_state == S_WR1) ? r_fwd : r_rev;
    assign w_wr_entry.valid = 1'b1;
    assign w_wr_entry.loss  = r_loss;
    assign w_wr_entry.stamp = r_now;

    lsc_table #(
        .DEPTH  (LinkCount),
        .ADDR_W (AddrW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_entry (w_wr_entry),
        .i_rd_en    (w_accept),
        .i_rd_addr  (w_fwd),
        .o_rd_entry (w_rd_entry),
        .o_busy     (w_busy)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_fwd    <= w_fwd;
                        r_rev    <= w_rev;
                        r_now    <= i_current_time;
                        r_sample <= i_normal_sample;
                        r_dev    <= w_dev;
                        if (r_enable && w_in_range) begin
                            r_state <= S_READ;
                        end else begin
                            r_loss    <= '0;
                            r_redrawn <= 1'b0;
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_READ: begin
                    r_acc   <= w_alu_res;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // borrow set when elapsed exceeds the coherence time
                    if (!w_rd_entry.valid || w_alu_res[lsc_pkg::ALU_W-1]) begin
                        r_redrawn <= 1'b1;
                        r_state   <= S_MUL;
                    end else begin
                        r_loss    <= w_rd_entry.loss;
                        r_redrawn <= 1'b0;
                        r_state   <= S_DONE;
                    end
                end
                S_MUL: begin
                    r_acc   <= w_alu_res;
                    r_neg   <= w_alu_res[lsc_pkg::ALU_W-1];
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    if (r_neg) begin
                        r_acc <= w_alu_res;
                    end
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_acc   <= lsc_pkg::ALU_W'((w_q > w_limit) ? w_limit : w_q);
                    r_state <= S_NEG;
                end
                S_NEG: begin
                    r_loss  <= r_neg ? w_alu_res[15:0] : r_acc[15:0];
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_state <= r_symmetric ? S_WR2 : S_DONE;
                end
                S_WR2: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_loss    <= r_loss;
                        r_out_redrawn <= r_redrawn;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_shadow_loss = r_out_loss;
    assign o_redrawn     = r_out_redrawn;

endmodule

`default_nettype wire
